/* hw/rtl/cnv3_pkg.sv */
// shared types and constants of the 3x3 convolution block
package cnv3_pkg;

  // geometry limits and field widths
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_CHANNELS = 4;
  localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int CH_W    = 2;
  localparam int WIDTH_W = 11;
  localparam int HEIGHT_W = 13;
  localparam int CHANS_W = 3;
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int KROW_W  = 48;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_TOP    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MIDDLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ADD_OFFSET    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd6;

  // reset values of the configuration registers
  localparam logic [KROW_W-1:0]   KERNEL_IDENTITY_ROW = 48'h0000_0100_0000;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd4096;
  localparam logic [CHANS_W-1:0]  CHANS_RESET  = 3'd3;

  // saturated frame geometry
  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [CHANS_W-1:0]  chans;
  } cnv3_geom_t;

  // position tag that travels with a filtered sample
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [CH_W-1:0]  channel;
    logic             last;
  } cnv3_meta_t;

  // 3x3 neighborhood, indexed [column][row], column 2 and row 2 newest
  typedef logic [2:0][2:0][PIX_W-1:0] cnv3_taps_t;

endpackage

/* hw/rtl/convolution_3x3_clamped_core.sv */
// top level: 3x3 clamped convolution over a raster sample stream
// throughput: one sample per cycle, set by the one-read one-write line store ram
// back-pressure on the output only stalls the input once all stages hold beats
// reset clears positions, pipeline valids and config registers (identity kernel);
// line stores and column window are not cleared and fill as the frame streams in
module convolution_3x3_clamped_core #(
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cnv3_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [cnv3_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [cnv3_pkg::PIX_W-1:0]           sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [cnv3_pkg::PIX_W-1:0]           filtered_value_o,
  output logic [cnv3_pkg::ROW_W-1:0]           out_row_o,
  output logic [cnv3_pkg::COL_W-1:0]           out_column_o,
  output logic [cnv3_pkg::CH_W-1:0]            out_channel_o,
  output logic                                 frame_last_o
);

  logic [2:0][cnv3_pkg::KROW_W-1:0]  kernel_q;
  logic                              add_offset_q;
  logic [cnv3_pkg::WIDTH_W-1:0]      width_q;
  logic [cnv3_pkg::HEIGHT_W-1:0]     height_q;
  logic [cnv3_pkg::CHANS_W-1:0]      chans_q;

  cnv3_pkg::cnv3_geom_t geom;
  cnv3_pkg::cnv3_taps_t taps;
  cnv3_pkg::cnv3_meta_t tap_meta;
  cnv3_pkg::cnv3_meta_t out_meta;
  logic tap_valid;
  logic tap_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q[0]  <= '0;
      kernel_q[1]  <= cnv3_pkg::KERNEL_IDENTITY_ROW;
      kernel_q[2]  <= '0;
      add_offset_q <= 1'b0;
      width_q      <= cnv3_pkg::WIDTH_RESET;
      height_q     <= cnv3_pkg::HEIGHT_RESET;
      chans_q      <= cnv3_pkg::CHANS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cnv3_pkg::REG_KERNEL_TOP:    kernel_q[0]  <= cfg_wdata_i;
        cnv3_pkg::REG_KERNEL_MIDDLE: kernel_q[1]  <= cfg_wdata_i;
        cnv3_pkg::REG_KERNEL_BOTTOM: kernel_q[2]  <= cfg_wdata_i;
        cnv3_pkg::REG_ADD_OFFSET:    add_offset_q <= cfg_wdata_i[0];
        cnv3_pkg::REG_IMAGE_WIDTH:   width_q  <= cfg_wdata_i[cnv3_pkg::WIDTH_W-1:0];
        cnv3_pkg::REG_IMAGE_HEIGHT:  height_q <= cfg_wdata_i[cnv3_pkg::HEIGHT_W-1:0];
        cnv3_pkg::REG_CHANNEL_COUNT: chans_q  <= cfg_wdata_i[cnv3_pkg::CHANS_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry saturated to the supported range
  always_comb begin
    if (width_q < 11'd3) begin
      geom.width = 11'd3;
    end else if (width_q > 11'(cnv3_pkg::MAX_WIDTH)) begin
      geom.width = 11'(cnv3_pkg::MAX_WIDTH);
    end else begin
      geom.width = width_q;
    end
    if (height_q < 13'd3) begin
      geom.height = 13'd3;
    end else if (height_q > 13'(cnv3_pkg::MAX_HEIGHT)) begin
      geom.height = 13'(cnv3_pkg::MAX_HEIGHT);
    end else begin
      geom.height = height_q;
    end
    if (chans_q < 3'd1) begin
      geom.chans = 3'd1;
    end else if (chans_q > 3'(cnv3_pkg::MAX_CHANNELS)) begin
      geom.chans = 3'(cnv3_pkg::MAX_CHANNELS);
    end else begin
      geom.chans = chans_q;
    end
  end

  // window assembly with line stores
  cnv3_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .geom_i      (geom),
    .tap_valid_o (tap_valid),
    .tap_ready_i (tap_ready),
    .taps_o      (taps),
    .meta_o      (tap_meta)
  );

  // filter arithmetic and output register
  cnv3_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tap_valid_i      (tap_valid),
    .tap_ready_o      (tap_ready),
    .taps_i           (taps),
    .meta_i           (tap_meta),
    .kernel_i         (kernel_q),
    .add_offset_i     (add_offset_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_value_o (filtered_value_o),
    .meta_o           (out_meta)
  );

  assign out_row_o     = out_meta.row;
  assign out_column_o  = out_meta.column;
  assign out_channel_o = out_meta.channel;
  assign frame_last_o  = out_meta.last;

endmodule

/* hw/rtl/cnv3_ram.sv */
// generic single write port memory with registered read
module cnv3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/cnv3_window.sv */
// raster position tracking, line stores and 3x3 window assembly
module cnv3_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [cnv3_pkg::PIX_W-1:0] sample_i,
  input  cnv3_pkg::cnv3_geom_t       geom_i,
  output logic                       tap_valid_o,
  input  logic                       tap_ready_i,
  output cnv3_pkg::cnv3_taps_t       taps_o,
  output cnv3_pkg::cnv3_meta_t       meta_o
);

  localparam int AddrW = $clog2(cnv3_pkg::STORE_DEPTH);
  localparam int PixW  = cnv3_pkg::PIX_W;

  logic [cnv3_pkg::ROW_W-1:0] row_q;
  logic [cnv3_pkg::COL_W-1:0] col_q;
  logic [cnv3_pkg::CH_W-1:0]  ch_q;

  logic             s1_valid_q;
  logic             s1_emit_q;
  logic [PixW-1:0]  s1_sample_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [cnv3_pkg::CH_W-1:0] s1_ch_q;
  cnv3_pkg::cnv3_meta_t s1_meta_q;

  logic [2:0][PixW-1:0] win_q [2][cnv3_pkg::MAX_CHANNELS];

  logic                 accept;
  logic                 s1_leave;
  logic                 ch_wrap;
  logic                 col_wrap;
  logic                 row_wrap;
  logic [AddrW-1:0]     rd_addr;
  logic [2*PixW-1:0]    ram_rdata;
  logic [2*PixW-1:0]    ram_wdata;
  logic [2:0][PixW-1:0] cur_col;

  // handshake: stage one leaves when done or when the datapath takes it
  assign s1_leave   = s1_valid_q && (!s1_emit_q || tap_ready_i);
  assign in_stall_o = s1_valid_q && !s1_leave;
  assign accept     = in_valid_i && !in_stall_o;

  // wrap conditions against the saturated geometry
  assign ch_wrap  = ({1'b0, ch_q} + 3'd1) >= geom_i.chans;
  assign col_wrap = ({1'b0, col_q} + 11'd1) >= geom_i.width;
  assign row_wrap = ({1'b0, row_q} + 13'd1) >= geom_i.height;

  // raster position counters, channel fastest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      ch_q  <= '0;
    end else if (accept) begin
      if (ch_wrap) begin
        ch_q <= '0;
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_wrap ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end else begin
        ch_q <= ch_q + 1'b1;
      end
    end
  end

  // stage one control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_leave) begin
      s1_valid_q <= 1'b0;
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q       <= sample_i;
      s1_addr_q         <= rd_addr;
      s1_ch_q           <= ch_q;
      s1_emit_q         <= (row_q >= 12'd2) && (col_q >= 10'd2);
      s1_meta_q.row     <= row_q - 1'b1;
      s1_meta_q.column  <= col_q - 1'b1;
      s1_meta_q.channel <= ch_q;
      s1_meta_q.last    <= ch_wrap && col_wrap && row_wrap;
    end
  end

  // both line stores share one word: older row high, newer row low
  assign rd_addr   = {col_q, ch_q};
  assign ram_wdata = {ram_rdata[PixW-1:0], s1_sample_q};

  cnv3_ram #(
    .WIDTH (2 * PixW),
    .DEPTH (cnv3_pkg::STORE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_leave),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // current column: top from older row, middle from newer row, bottom new
  assign cur_col[0] = ram_rdata[2*PixW-1:PixW];
  assign cur_col[1] = ram_rdata[PixW-1:0];
  assign cur_col[2] = s1_sample_q;

  // per-channel history of the two previous columns
  always_ff @(posedge clk_i) begin
    if (s1_leave) begin
      win_q[0][s1_ch_q] <= win_q[1][s1_ch_q];
      win_q[1][s1_ch_q] <= cur_col;
    end
  end

  assign taps_o[0]   = win_q[0][s1_ch_q];
  assign taps_o[1]   = win_q[1][s1_ch_q];
  assign taps_o[2]   = cur_col;
  assign meta_o      = s1_meta_q;
  assign tap_valid_o = s1_valid_q && s1_emit_q;

  // a new read never hits the address still waiting for its write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_leave) |-> (rd_addr != s1_addr_q))
    else $error("line store read collides with pending write");

  // stall only while stage one holds a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_emit_q))
    else $error("input stalled without a waiting beat");

  // accepted beat shows up in stage one at the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted beat lost before stage one");

endmodule

/* hw/rtl/cnv3_mac.sv */
// multiply, row sums, total with optional offset, floor and clamp to 8 bits
module cnv3_mac #(
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                tap_valid_i,
  output logic                                tap_ready_o,
  input  cnv3_pkg::cnv3_taps_t                taps_i,
  input  cnv3_pkg::cnv3_meta_t                meta_i,
  input  logic [2:0][cnv3_pkg::KROW_W-1:0]    kernel_i,
  input  logic                                add_offset_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cnv3_pkg::PIX_W-1:0]          filtered_value_o,
  output cnv3_pkg::cnv3_meta_t                meta_o
);

  localparam int ProdW  = cnv3_pkg::PIX_W + 1 + cnv3_pkg::COEF_W;
  localparam int RowW   = ProdW + 2;
  localparam int TotW   = RowW + 2;
  localparam int OffsetValue = 127 * (1 << COEF_FRAC_BITS);
  localparam logic [cnv3_pkg::PIX_W-1:0] PixMax = 8'd255;

  logic signed [ProdW-1:0] prod_d [3][3];
  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [RowW-1:0]  rsum_d [3];
  logic signed [RowW-1:0]  rsum_q [3];
  logic signed [TotW-1:0]  total;
  logic [cnv3_pkg::PIX_W-1:0] value_d;

  logic p_valid_q, r_valid_q, o_valid_q;
  logic p_ready, r_ready, o_ready;
  cnv3_pkg::cnv3_meta_t p_meta_q, r_meta_q, o_meta_q;
  logic [cnv3_pkg::PIX_W-1:0] o_value_q;

  // pipeline handshake, bubbles collapse
  assign o_ready     = !o_valid_q || !out_stall_i;
  assign r_ready     = !r_valid_q || o_ready;
  assign p_ready     = !p_valid_q || r_ready;
  assign tap_ready_o = p_ready;

  // products: tap (dy,dx) meets the 180-degree rotated coefficient
  always_comb begin
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        prod_d[dy][dx] = $signed({1'b0, taps_i[dx][dy]})
                       * $signed(kernel_i[2-dy][16*dx +: cnv3_pkg::COEF_W]);
      end
    end
  end

  // row sums
  always_comb begin
    for (int dy = 0; dy < 3; dy++) begin
      rsum_d[dy] = RowW'(prod_q[dy][0]) + RowW'(prod_q[dy][1])
                 + RowW'(prod_q[dy][2]);
    end
  end

  // total with optional offset, then floor and clamp
  always_comb begin
    total = TotW'(rsum_q[0]) + TotW'(rsum_q[1]) + TotW'(rsum_q[2])
          + (add_offset_i ? TotW'(OffsetValue) : TotW'(0));
    if (total[TotW-1]) begin
      value_d = '0;
    end else if (|total[TotW-1:COEF_FRAC_BITS+cnv3_pkg::PIX_W]) begin
      value_d = PixMax;
    end else begin
      value_d = total[COEF_FRAC_BITS +: cnv3_pkg::PIX_W];
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (p_ready) p_valid_q <= tap_valid_i;
      if (r_ready) r_valid_q <= p_valid_q;
      if (o_ready) o_valid_q <= r_valid_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (p_ready && tap_valid_i) begin
      prod_q   <= prod_d;
      p_meta_q <= meta_i;
    end
    if (r_ready && p_valid_q) begin
      rsum_q   <= rsum_d;
      r_meta_q <= p_meta_q;
    end
    if (o_ready && r_valid_q) begin
      o_value_q <= value_d;
      o_meta_q  <= r_meta_q;
    end
  end

  assign out_valid_o      = o_valid_q;
  assign filtered_value_o = o_value_q;
  assign meta_o           = o_meta_q;

  // only interior samples leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q |-> (o_meta_q.row != '0 && o_meta_q.column != '0))
    else $error("border sample emitted");

endmodule

/* test/convolution_3x3_clamped_checker.sv */
`timescale 1ns / 100ps
// checker for the 3x3 convolution core: predicts each filtered beat and compares output beats
module convolution_3x3_clamped_checker
  import cnv3_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [PIX_W-1:0]       sample_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [PIX_W-1:0]       filtered_value_i,
  input  logic [ROW_W-1:0]       out_row_i,
  input  logic [COL_W-1:0]       out_column_i,
  input  logic [CH_W-1:0]        out_channel_i,
  input  logic                   frame_last_i,
  output int                     errors_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [PIX_W-1:0] value;
    cnv3_meta_t       tag;
  } filtered_beat_t;

  // configuration copy
  logic [KROW_W-1:0]   kernel_rows [3];
  logic                add_offset;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [CHANS_W-1:0]  chans_reg;

  // line stores, column window [age][channel][row tap], raster position
  logic [PIX_W-1:0] older_line [STORE_DEPTH];
  logic [PIX_W-1:0] newer_line [STORE_DEPTH];
  logic [PIX_W-1:0] window_cols [2][MAX_CHANNELS][3];
  int unsigned      row_pos;
  int unsigned      col_pos;
  int unsigned      ch_pos;

  filtered_beat_t expected_filtered [$];
  int             mismatch_count;

  assign errors_o = mismatch_count;

  function automatic int unsigned saturate(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // take one input beat: queue its filtered value if it completes an interior window
  task automatic absorb_sample(input logic [PIX_W-1:0] pix);
    int unsigned width, height, chans, ch, col, row, at;
    logic [PIX_W-1:0] column_now [3];
    logic [PIX_W-1:0] pixel;
    logic signed [COEF_W-1:0] coef;
    longint acc;
    longint scaled;
    filtered_beat_t beat;
    width  = saturate(32'(width_reg), 3, MAX_WIDTH);
    height = saturate(32'(height_reg), 3, MAX_HEIGHT);
    chans  = saturate(32'(chans_reg), 1, MAX_CHANNELS);
    ch  = ch_pos % MAX_CHANNELS;
    col = col_pos % MAX_WIDTH;
    row = row_pos % MAX_HEIGHT;
    at  = col * MAX_CHANNELS + ch;
    column_now[0] = older_line[at];
    column_now[1] = newer_line[at];
    column_now[2] = pix;

    if (row >= 2 && col >= 2) begin
      // kernel rotated by 180 degrees: the oldest column meets the right coefficient
      acc = 0;
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          coef  = kernel_rows[2 - dy][dx * COEF_W +: COEF_W];
          pixel = (dx == 2) ? column_now[dy] : window_cols[dx][ch][dy];
          acc  += longint'(pixel) * longint'(coef);
        end
      end
      if (add_offset) acc += longint'(127) << FRAC_BITS;
      // floor, then clamp to the pixel range
      if (acc < 0) begin
        beat.value = '0;
      end else begin
        scaled = acc >>> FRAC_BITS;
        beat.value = (scaled > 255) ? 8'hFF : PIX_W'(scaled);
      end
      beat.tag.row     = ROW_W'(row - 1);
      beat.tag.column  = COL_W'(col - 1);
      beat.tag.channel = CH_W'(ch);
      beat.tag.last    = (row + 1 >= height) && (col + 1 >= width) && (ch + 1 >= chans);
      expected_filtered.push_back(beat);
    end

    // shift the window and write the line stores
    for (int dy = 0; dy < 3; dy++) begin
      window_cols[0][ch][dy] = window_cols[1][ch][dy];
      window_cols[1][ch][dy] = column_now[dy];
    end
    older_line[at] = column_now[1];
    newer_line[at] = pix;

    // advance channel, column, row
    if (ch_pos + 1 >= chans) begin
      ch_pos = 0;
      if (col_pos + 1 >= width) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= height) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    end else begin
      ch_pos++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filtered_beat_t oldest;
    if (!rst_ni) begin
      kernel_rows[0] = '0;
      kernel_rows[1] = KERNEL_IDENTITY_ROW;
      kernel_rows[2] = '0;
      add_offset     = 1'b0;
      width_reg      = WIDTH_RESET;
      height_reg     = HEIGHT_RESET;
      chans_reg      = CHANS_RESET;
      row_pos        = 0;
      col_pos        = 0;
      ch_pos         = 0;
      mismatch_count = 0;
      expected_filtered.delete();
      for (int i = 0; i < STORE_DEPTH; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      for (int a = 0; a < 2; a++)
        for (int c = 0; c < MAX_CHANNELS; c++)
          for (int t = 0; t < 3; t++) window_cols[a][c][t] = '0;
    end else begin
      // output beat against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_filtered.size() == 0) begin
          $error("result beat with nothing expected: value %0d row %0d column %0d channel %0d",
                 filtered_value_i, out_row_i, out_column_i, out_channel_i);
          mismatch_count++;
        end else begin
          oldest = expected_filtered.pop_front();
          check_field("filtered_value", 16'(oldest.value), 16'(filtered_value_i));
          check_field("out_row", 16'(oldest.tag.row), 16'(out_row_i));
          check_field("out_column", 16'(oldest.tag.column), 16'(out_column_i));
          check_field("out_channel", 16'(oldest.tag.channel), 16'(out_channel_i));
          check_field("frame_last", 16'(oldest.tag.last), 16'(frame_last_i));
        end
      end

      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_KERNEL_TOP:    kernel_rows[0] = cfg_wdata_i[KROW_W-1:0];
          REG_KERNEL_MIDDLE: kernel_rows[1] = cfg_wdata_i[KROW_W-1:0];
          REG_KERNEL_BOTTOM: kernel_rows[2] = cfg_wdata_i[KROW_W-1:0];
          REG_ADD_OFFSET:    add_offset     = cfg_wdata_i[0];
          REG_IMAGE_WIDTH:   width_reg      = cfg_wdata_i[WIDTH_W-1:0];
          REG_IMAGE_HEIGHT:  height_reg     = cfg_wdata_i[HEIGHT_W-1:0];
          REG_CHANNEL_COUNT: chans_reg      = cfg_wdata_i[CHANS_W-1:0];
          default: ;
        endcase
      end

      // input beat
      if (in_valid_i && !in_stall_i) absorb_sample(sample_i);
    end
    pending_o <= expected_filtered.size();
  end

endmodule

/* test/convolution_3x3_clamped_core_test.sv */
`timescale 1ns / 100ps
// stimulus and verdict for the 3x3 clamped convolution core
module convolution_3x3_clamped_core_test;
  import cnv3_pkg::*;

  localparam int COEF_FRAC_BITS  = 8;
  localparam int RANDOM_ITEMS    = 300;
  localparam int IDLE_PERCENT    = 15;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_FRAME_W    = 12;
  localparam int HOLD_FRAME_H    = 5;
  localparam int HOLD_FRAME_C    = 4;
  localparam int HOLD_SPLIT      = 130;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic [PIX_W-1:0]       sample;
  logic                   out_valid;
  logic                   out_stall;
  logic [PIX_W-1:0]       filtered_value;
  logic [ROW_W-1:0]       out_row;
  logic [COL_W-1:0]       out_column;
  logic [CH_W-1:0]        out_channel;
  logic                   frame_last;
  int                     checker_errors;
  int                     pending_results;
  logic                   calm;
  logic                   hold_go;
  int                     quiet_cycles;

  convolution_3x3_clamped_core #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .sample_i         (sample),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .filtered_value_o (filtered_value),
    .out_row_o        (out_row),
    .out_column_o     (out_column),
    .out_channel_o    (out_channel),
    .frame_last_o     (frame_last)
  );

  convolution_3x3_clamped_checker #(
    .FRAC_BITS(COEF_FRAC_BITS)
  ) filtered_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .sample_i         (sample),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .filtered_value_i (filtered_value),
    .out_row_i        (out_row),
    .out_column_i     (out_column),
    .out_channel_i    (out_channel),
    .frame_last_i     (frame_last),
    .errors_o         (checker_errors),
    .pending_o        (pending_results)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold-off mid-frame
  initial begin
    bit hold_done;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_kernel(input logic [KROW_W-1:0] top_row, input logic [KROW_W-1:0] mid_row,
                            input logic [KROW_W-1:0] bot_row, input logic offset);
    write_reg(REG_KERNEL_TOP, top_row);
    write_reg(REG_KERNEL_MIDDLE, mid_row);
    write_reg(REG_KERNEL_BOTTOM, bot_row);
    write_reg(REG_ADD_OFFSET, CFG_DATA_W'(offset));
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned c);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(c));
  endtask

  // mostly small coefficients, some zero, some anywhere in the 16-bit range
  function automatic logic [COEF_W-1:0] random_coef();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 30) return COEF_W'($urandom);
    return COEF_W'(int'($urandom_range(1024)) - 512);
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic load_random_kernel();
    set_kernel({random_coef(), random_coef(), random_coef()},
               {random_coef(), random_coef(), random_coef()},
               {random_coef(), random_coef(), random_coef()}, 1'($urandom_range(1)));
  endtask

  // one sample beat, with a random gap before it
  task automatic push_sample(input logic [PIX_W-1:0] value);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending, wait for every expected beat, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int unsigned sent, frame_no, w, h, c;
    int unsigned w_wr, h_wr, c_wr;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    sample    <= '0;
    calm      <= 1'b0;
    hold_go   <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // largest positive kernel with offset: sum saturates high
    set_kernel(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 1'b1);
    set_geometry(3, 3, 1);
    for (int i = 0; i < 9; i++) push_sample(i[0] ? 8'hFF : 8'h00);
    settle();

    // most negative kernel on white: sum floors at zero
    set_kernel(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 1'b0);
    for (int i = 0; i < 9; i++) push_sample(8'hFF);
    settle();

    // geometry below range saturates to 3x3 with one channel, identity plus offset
    set_kernel('0, KERNEL_IDENTITY_ROW, '0, 1'b1);
    set_geometry(0, 2, 0);
    for (int i = 0; i < 9; i++) push_sample(PIX_W'(i * 31));
    settle();

    // narrower width written mid-row: the current row wraps at its next advance
    load_random_kernel();
    set_geometry(8, 6, 2);
    repeat (58) push_sample(random_pixel());
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
    repeat (18) push_sample(random_pixel());
    settle();

    // random frames, mostly small, two of them with no idling on either side
    sent = 0;
    frame_no = 0;
    while (sent < RANDOM_ITEMS) begin
      calm <= (frame_no >= 1 && frame_no < 3);
      load_random_kernel();
      if ($urandom_range(7) == 0) begin
        w = $urandom_range(13, 40);
        h = 3;
        c = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 6);
        c = $urandom_range(1, 4);
      end
      // out-of-range writes that saturate to the chosen geometry
      w_wr = (w == 3 && $urandom_range(1)) ? $urandom_range(2) : w;
      h_wr = (h == 3 && $urandom_range(1)) ? $urandom_range(2) : h;
      if (c == 1 && $urandom_range(1)) c_wr = 0;
      else if (c == 4 && $urandom_range(1)) c_wr = $urandom_range(5, 7);
      else c_wr = c;
      set_geometry(w_wr, h_wr, c_wr);
      repeat (w * h * c) push_sample(random_pixel());
      settle();
      sent += w * h * c;
      frame_no++;
    end
    calm <= 1'b0;

    // receiver holds off mid-frame while the sender keeps offering beats
    load_random_kernel();
    set_geometry(HOLD_FRAME_W, HOLD_FRAME_H, HOLD_FRAME_C);
    repeat (HOLD_SPLIT) push_sample(random_pixel());
    hold_go <= 1'b1;
    repeat (HOLD_FRAME_W * HOLD_FRAME_H * HOLD_FRAME_C - HOLD_SPLIT) push_sample(random_pixel());
    settle();

    repeat (20) @(posedge clk);
    if (checker_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
